[rtl/fuel_counter_flow_meter_unit_macros.svh]
// ----------------------------------------------------------------------------
// Fuel flow meter assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef FUEL_COUNTER_FLOW_METER_UNIT_MACROS_SVH
`define FUEL_COUNTER_FLOW_METER_UNIT_MACROS_SVH

// same-cycle implication
`define FCFM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FCFM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/fcfm_pkg.sv]
// ----------------------------------------------------------------------------
// Fuel flow meter package
// Shared widths, register indexes, item kinds and state encodings.
// ----------------------------------------------------------------------------
package fcfm_pkg;

	// defaults for the top level parameters
	localparam int NUM_BUCKETS_DEF  = 4;
	localparam int COUNTER_BITS_DEF = 15;

	// decoupling queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// fixed field widths
	localparam int ITEM_W        = 16;
	localparam int BUCKET_W      = 16;
	localparam int TIME_W        = 32;
	localparam int FLOW_W        = 32;
	localparam int RESTART_W     = 16;
	localparam int BUCKET_TIME_W = 14;
	localparam int WINDOW_W      = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 16;

	// flow scaling
	localparam int MS_PER_S   = 1000;
	localparam int MS_PER_S_W = 10;

	// configuration reset values
	localparam logic [BUCKET_TIME_W-1:0] BUCKET_TIME_RST = 14'd250;
	localparam logic [WINDOW_W-1:0]      WINDOW_TIME_RST = 16'd1000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_TIME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TIME = 1'b1;

	// how the back end must treat an item
	typedef enum logic [2:0] {
		KIND_INVALID,
		KIND_RESTART,
		KIND_SEED,
		KIND_HOLD,
		KIND_ADD,
		KIND_CLEAR
	} item_kind_t;

	// classified item passed from front to back
	typedef struct packed {
		item_kind_t          kind;
		logic                restart;
		logic [ITEM_W-1:0]   delta;
		logic [ITEM_W-1:0]   dt;
	} item_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SUM,
		BK_SCALE,
		BK_DIV,
		BK_OUT
	} back_state_t;

endpackage

[rtl/fcfm_front.sv]
// ----------------------------------------------------------------------------
// Fuel flow meter front end
// Tracks the previous counter sample and classifies each incoming item.
// ----------------------------------------------------------------------------
module fcfm_front #(
	parameter int COUNTER_BITS = fcfm_pkg::COUNTER_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic                               counter_valid,
	input  logic [COUNTER_BITS-1:0]            fuel_count,
	input  logic                               engine_turning,
	input  logic [fcfm_pkg::TIME_W-1:0]        time_ms,
	input  logic [fcfm_pkg::WINDOW_W-1:0]      window_time,
	output fcfm_pkg::item_t                    item
);

	localparam int ITEM_W = fcfm_pkg::ITEM_W;
	localparam int TIME_W = fcfm_pkg::TIME_W;

	logic [COUNTER_BITS-1:0] prev_count_q;
	logic [TIME_W-1:0]       prev_time_q;
	logic                    have_prev_q;

	logic [TIME_W-1:0]       dt;
	logic [COUNTER_BITS-1:0] delta;

	// classify against the previous sample
	always_comb begin
		dt           = time_ms - prev_time_q;
		delta        = fuel_count - prev_count_q;
		item         = '0;
		item.kind    = fcfm_pkg::KIND_INVALID;
		if (!counter_valid) begin
			item.kind = fcfm_pkg::KIND_INVALID;
		end else if (fuel_count == '0 || !engine_turning) begin
			item.kind    = fcfm_pkg::KIND_RESTART;
			item.restart = have_prev_q;
		end else if (!have_prev_q) begin
			item.kind = fcfm_pkg::KIND_SEED;
		end else begin
			item.delta = ITEM_W'(delta);
			item.dt    = dt[ITEM_W-1:0];
			if (dt == '0) begin
				item.kind = fcfm_pkg::KIND_HOLD;
			end else if (dt <= TIME_W'(window_time)) begin
				item.kind = fcfm_pkg::KIND_ADD;
			end else begin
				item.kind = fcfm_pkg::KIND_CLEAR;
			end
		end
	end

	// every accepted valid sample re-seeds the reference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_count_q <= '0;
			prev_time_q  <= '0;
			have_prev_q  <= 1'b0;
		end else if (accept && counter_valid) begin
			prev_count_q <= fuel_count;
			prev_time_q  <= time_ms;
			have_prev_q  <= 1'b1;
		end
	end

endmodule

[rtl/fcfm_queue.sv]
// ----------------------------------------------------------------------------
// Fuel flow meter item queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module fcfm_queue #(
	parameter int DEPTH = fcfm_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  fcfm_pkg::item_t wr_item,
	input  logic            rd_en,
	output fcfm_pkg::item_t rd_item,
	output logic            q_full,
	output logic            q_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	fcfm_pkg::item_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/fcfm_back.sv]
// ----------------------------------------------------------------------------
// Fuel flow meter back end
// Bucket ring, restart count, flow average with iterative divider, result slot.
// ----------------------------------------------------------------------------
module fcfm_back #(
	parameter int NUM_BUCKETS  = fcfm_pkg::NUM_BUCKETS_DEF,
	parameter int COUNTER_BITS = fcfm_pkg::COUNTER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [fcfm_pkg::BUCKET_TIME_W-1:0]  bucket_time,
	input  fcfm_pkg::item_t                     q_item,
	input  logic                                q_empty,
	output logic                                q_pop,
	input  logic                                pop,
	output logic                                empty,
	output logic                                accepted,
	output logic [COUNTER_BITS-1:0]             burned_ul,
	output logic                                restart_seen,
	output logic [fcfm_pkg::RESTART_W-1:0]      restart_total,
	output logic                                flow_updated,
	output logic [fcfm_pkg::FLOW_W-1:0]         flow_ul_per_s
);

	localparam int BUCKET_W  = fcfm_pkg::BUCKET_W;
	localparam int FLOW_W    = fcfm_pkg::FLOW_W;
	localparam int RESTART_W = fcfm_pkg::RESTART_W;
	localparam int IDX_W     = $clog2(NUM_BUCKETS);
	localparam int SUM_W     = BUCKET_W + $clog2(NUM_BUCKETS);
	localparam int NUM_W     = SUM_W + fcfm_pkg::MS_PER_S_W + 1;
	localparam int DCNT_W    = $clog2(NUM_W);

	fcfm_pkg::back_state_t state_q, state_nxt;

	// bucket ring and running state
	logic [BUCKET_W-1:0]  vol_q [NUM_BUCKETS];
	logic [BUCKET_W-1:0]  dur_q [NUM_BUCKETS];
	logic [IDX_W-1:0]     open_q;
	logic [FLOW_W-1:0]    flow_q;
	logic [RESTART_W-1:0] restart_cnt_q;

	// closing sums and divider
	logic [IDX_W-1:0]     walk_q;
	logic [SUM_W-1:0]     sum_ul_q;
	logic [SUM_W-1:0]     sum_ms_q;
	logic [NUM_W-1:0]     numer_q;
	logic [SUM_W-1:0]     rem_q;
	logic [DCNT_W-1:0]    div_cnt_q;

	// pending result flags
	logic                    res_acc_q;
	logic [COUNTER_BITS-1:0] res_delta_q;
	logic                    res_restart_q;
	logic                    res_upd_q;

	// result slot
	logic                    out_valid_q;
	logic                    out_acc_q;
	logic [COUNTER_BITS-1:0] out_delta_q;
	logic                    out_restart_q;
	logic [RESTART_W-1:0]    out_total_q;
	logic                    out_upd_q;
	logic [FLOW_W-1:0]       out_flow_q;

	logic                 out_free;
	logic                 out_load;
	logic [IDX_W-1:0]     rd_idx;
	logic [BUCKET_W-1:0]  rd_vol;
	logic [BUCKET_W-1:0]  rd_dur;
	logic [BUCKET_W-1:0]  new_vol;
	logic [BUCKET_W-1:0]  new_dur;
	logic                 close;
	logic [IDX_W-1:0]     open_nxt;
	logic                 walk_last;
	logic [NUM_W-1:0]     scaled;
	logic [SUM_W:0]       trial;
	logic                 q_bit;
	logic [SUM_W-1:0]     rem_nxt;
	logic [NUM_W-1:0]     numer_nxt;

	// single read port: open bucket when adding, walk index when summing
	assign rd_idx    = (state_q == fcfm_pkg::BK_SUM) ? walk_q : open_q;
	assign rd_vol    = vol_q[rd_idx];
	assign rd_dur    = dur_q[rd_idx];
	assign new_vol   = rd_vol + q_item.delta;
	assign new_dur   = rd_dur + q_item.dt;
	assign close     = (new_dur >= BUCKET_W'(bucket_time));
	assign open_nxt  = (open_q == IDX_W'(NUM_BUCKETS - 1)) ? '0 : open_q + 1'b1;
	assign walk_last = (walk_q == IDX_W'(NUM_BUCKETS - 1));

	// sum_ul * 1000 + sum_ms / 2
	assign scaled = NUM_W'(sum_ul_q) * NUM_W'(fcfm_pkg::MS_PER_S) + NUM_W'(sum_ms_q >> 1);

	// restoring divide, one quotient bit per cycle
	assign trial     = {rem_q, numer_q[NUM_W-1]};
	assign q_bit     = (trial >= {1'b0, sum_ms_q});
	assign rem_nxt   = q_bit ? SUM_W'(trial - {1'b0, sum_ms_q}) : trial[SUM_W-1:0];
	assign numer_nxt = {numer_q[NUM_W-2:0], q_bit};

	assign out_free = !out_valid_q || pop;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			fcfm_pkg::BK_IDLE: begin
				if (!q_empty) begin
					if (q_item.kind == fcfm_pkg::KIND_ADD && close) begin
						state_nxt = fcfm_pkg::BK_SUM;
					end else begin
						state_nxt = fcfm_pkg::BK_OUT;
					end
				end
			end
			fcfm_pkg::BK_SUM: begin
				if (walk_last) begin
					state_nxt = fcfm_pkg::BK_SCALE;
				end
			end
			fcfm_pkg::BK_SCALE: begin
				state_nxt = (sum_ms_q == '0) ? fcfm_pkg::BK_OUT : fcfm_pkg::BK_DIV;
			end
			fcfm_pkg::BK_DIV: begin
				if (div_cnt_q == '0) begin
					state_nxt = fcfm_pkg::BK_OUT;
				end
			end
			fcfm_pkg::BK_OUT: begin
				if (out_free) begin
					state_nxt = fcfm_pkg::BK_IDLE;
				end
			end
			default: begin
				state_nxt = fcfm_pkg::BK_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		q_pop    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			fcfm_pkg::BK_IDLE: q_pop    = !q_empty;
			fcfm_pkg::BK_OUT:  out_load = out_free;
			default: begin
				q_pop    = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	// state, bucket ring and running values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= fcfm_pkg::BK_IDLE;
			open_q        <= '0;
			flow_q        <= '0;
			restart_cnt_q <= '0;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				vol_q[i] <= '0;
				dur_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			case (state_q)
				fcfm_pkg::BK_IDLE: begin
					if (q_pop) begin
						case (q_item.kind)
							fcfm_pkg::KIND_RESTART,
							fcfm_pkg::KIND_CLEAR: begin
								if (q_item.restart) begin
									restart_cnt_q <= restart_cnt_q + 1'b1;
								end
								open_q <= '0;
								flow_q <= '0;
								for (int i = 0; i < NUM_BUCKETS; i++) begin
									vol_q[i] <= '0;
									dur_q[i] <= '0;
								end
							end
							fcfm_pkg::KIND_ADD: begin
								vol_q[open_q] <= new_vol;
								dur_q[open_q] <= new_dur;
							end
							default: begin
							end
						endcase
					end
				end
				fcfm_pkg::BK_SUM: begin
					// oldest bucket becomes the open one once it has been summed
					if (walk_last) begin
						open_q          <= open_nxt;
						vol_q[open_nxt] <= '0;
						dur_q[open_nxt] <= '0;
					end
				end
				fcfm_pkg::BK_SCALE: begin
					if (sum_ms_q == '0) begin
						flow_q <= '0;
					end
				end
				fcfm_pkg::BK_DIV: begin
					if (div_cnt_q == '0) begin
						flow_q <= FLOW_W'(numer_nxt);
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			fcfm_pkg::BK_IDLE: begin
				walk_q        <= '0;
				sum_ul_q      <= '0;
				sum_ms_q      <= '0;
				res_acc_q     <= (q_item.kind != fcfm_pkg::KIND_INVALID);
				res_delta_q   <= q_item.delta[COUNTER_BITS-1:0];
				res_restart_q <= q_item.restart;
				res_upd_q     <= (q_item.kind == fcfm_pkg::KIND_ADD) && close;
			end
			fcfm_pkg::BK_SUM: begin
				walk_q   <= walk_q + 1'b1;
				sum_ul_q <= sum_ul_q + SUM_W'(rd_vol);
				sum_ms_q <= sum_ms_q + SUM_W'(rd_dur);
			end
			fcfm_pkg::BK_SCALE: begin
				numer_q   <= scaled;
				rem_q     <= '0;
				div_cnt_q <= DCNT_W'(NUM_W - 1);
			end
			fcfm_pkg::BK_DIV: begin
				numer_q   <= numer_nxt;
				rem_q     <= rem_nxt;
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_acc_q     <= res_acc_q;
			out_delta_q   <= res_delta_q;
			out_restart_q <= res_restart_q;
			out_total_q   <= restart_cnt_q;
			out_upd_q     <= res_upd_q;
			out_flow_q    <= flow_q;
		end
	end

	assign empty         = !out_valid_q;
	assign accepted      = out_acc_q;
	assign burned_ul     = out_delta_q;
	assign restart_seen  = out_restart_q;
	assign restart_total = out_total_q;
	assign flow_updated  = out_upd_q;
	assign flow_ul_per_s = out_flow_q;

endmodule

[rtl/fuel_counter_flow_meter_unit.sv]
// Flow: the queue registers each accepted item; the back end pops it in BK_IDLE and
// loads the result slot in BK_OUT once the slot is free. A closing bucket first passes
// BK_SUM over all NUM_BUCKETS buckets, BK_SCALE and, for a nonzero time sum, BK_DIV:
// one quotient bit per cycle, 16+log2(NUM_BUCKETS)+11 bits (29 at defaults).
// The back end takes one item at a time; a 2-entry queue decouples the input from it.
// Reset: arst_n clears control, ring and config registers (250, 1000), not data storage.
// ----------------------------------------------------------------------------
// Fuel flow meter top level
// Front classifier, item queue, back end with bucket ring and flow divider.
// ----------------------------------------------------------------------------
`include "fuel_counter_flow_meter_unit_macros.svh"

module fuel_counter_flow_meter_unit #(
	parameter int NUM_BUCKETS  = fcfm_pkg::NUM_BUCKETS_DEF,
	parameter int COUNTER_BITS = fcfm_pkg::COUNTER_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fcfm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fcfm_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input items
	input  logic                               push,
	output logic                               full,
	input  logic                               counter_valid,
	input  logic [COUNTER_BITS-1:0]            fuel_count,
	input  logic                               engine_turning,
	input  logic [fcfm_pkg::TIME_W-1:0]        time_ms,
	// result items
	output logic                               empty,
	input  logic                               pop,
	output logic                               accepted,
	output logic [COUNTER_BITS-1:0]            burned_ul,
	output logic                               restart_seen,
	output logic [fcfm_pkg::RESTART_W-1:0]     restart_total,
	output logic                               flow_updated,
	output logic [fcfm_pkg::FLOW_W-1:0]        flow_ul_per_s
);

	logic [fcfm_pkg::BUCKET_TIME_W-1:0] bucket_time_q;
	logic [fcfm_pkg::WINDOW_W-1:0]      window_time_q;

	fcfm_pkg::item_t front_item;
	fcfm_pkg::item_t q_item;
	logic            q_full;
	logic            q_empty;
	logic            q_pop;
	logic            in_take;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign in_take   = push && !q_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_time_q <= fcfm_pkg::BUCKET_TIME_RST;
			window_time_q <= fcfm_pkg::WINDOW_TIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fcfm_pkg::REG_BUCKET_TIME: bucket_time_q <= cfg_data[fcfm_pkg::BUCKET_TIME_W-1:0];
				fcfm_pkg::REG_WINDOW_TIME: window_time_q <= cfg_data[fcfm_pkg::WINDOW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fcfm_front #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (in_take),
		.counter_valid  (counter_valid),
		.fuel_count     (fuel_count),
		.engine_turning (engine_turning),
		.time_ms        (time_ms),
		.window_time    (window_time_q),
		.item           (front_item)
	);

	fcfm_queue #(
		.DEPTH (fcfm_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_take),
		.wr_item (front_item),
		.rd_en   (q_pop),
		.rd_item (q_item),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	fcfm_back #(
		.NUM_BUCKETS  (NUM_BUCKETS),
		.COUNTER_BITS (COUNTER_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.bucket_time   (bucket_time_q),
		.q_item        (q_item),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.accepted      (accepted),
		.burned_ul     (burned_ul),
		.restart_seen  (restart_seen),
		.restart_total (restart_total),
		.flow_updated  (flow_updated),
		.flow_ul_per_s (flow_ul_per_s)
	);

	// a restart result reports no fuel and a cleared flow
	`FCFM_ASSERT_IMP(a_restart_clears, !empty && restart_seen, accepted && burned_ul == '0 && !flow_updated && flow_ul_per_s == '0, "restart result not cleared")
	// back end never dequeues from an empty queue
	`FCFM_ASSERT_IMP(a_no_pop_empty, q_pop, !q_empty, "dequeue from empty queue")
	// an accepted item is held in the queue on the next cycle
	`FCFM_ASSERT_NXT(a_push_lands, in_take, !q_empty, "accepted item lost")

endmodule

[tb/tb_fuel_counter_flow_meter_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fuel flow meter testbench
// Feeds timestamped fuel counter samples through the input queue interface,
// predicts every result with a local copy of the meter state, and checks the
// results field by field. It runs directed corner cases first, then random
// sample streams under several register settings, with random idling on both
// sides and one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_fuel_counter_flow_meter_unit;

	localparam int NB          = fcfm_pkg::NUM_BUCKETS_DEF;
	localparam int CB          = fcfm_pkg::COUNTER_BITS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 40;
	localparam int LONG_HOLD   = 400;

	typedef struct packed {
		logic          valid;
		logic [CB-1:0] count;
		logic          turning;
		logic [31:0]   stamp;
	} sample_t;

	typedef struct packed {
		logic                           accepted;
		logic [CB-1:0]                  delta;
		logic                           restart_seen;
		logic [fcfm_pkg::RESTART_W-1:0] restarts;
		logic                           flow_updated;
		logic [fcfm_pkg::FLOW_W-1:0]    flow;
	} meter_reading_t;

	// DUT signals
	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [fcfm_pkg::CFG_IDX_W-1:0]  cfg_index = fcfm_pkg::REG_BUCKET_TIME;
	logic [fcfm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            push = 1'b0;
	logic                            full;
	logic                            counter_valid = 1'b0;
	logic [CB-1:0]                   fuel_count = '0;
	logic                            engine_turning = 1'b0;
	logic [fcfm_pkg::TIME_W-1:0]     time_ms = '0;
	logic                            empty;
	logic                            pop = 1'b0;
	logic                            accepted;
	logic [CB-1:0]                   burned_ul;
	logic                            restart_seen;
	logic [fcfm_pkg::RESTART_W-1:0]  restart_total;
	logic                            flow_updated;
	logic [fcfm_pkg::FLOW_W-1:0]     flow_ul_per_s;

	fuel_counter_flow_meter_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.counter_valid (counter_valid),
		.fuel_count    (fuel_count),
		.engine_turning(engine_turning),
		.time_ms       (time_ms),
		.empty         (empty),
		.pop           (pop),
		.accepted      (accepted),
		.burned_ul     (burned_ul),
		.restart_seen  (restart_seen),
		.restart_total (restart_total),
		.flow_updated  (flow_updated),
		.flow_ul_per_s (flow_ul_per_s)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted meter state and register copies
	logic [fcfm_pkg::BUCKET_TIME_W-1:0] bucket_time_cfg = fcfm_pkg::BUCKET_TIME_RST;
	logic [fcfm_pkg::WINDOW_W-1:0]      window_cfg      = fcfm_pkg::WINDOW_TIME_RST;
	logic [CB-1:0]                      last_count      = '0;
	logic                               have_last       = 1'b0;
	logic [31:0]                        last_stamp      = '0;
	logic [fcfm_pkg::BUCKET_W-1:0]      ring_ul [NB];
	logic [fcfm_pkg::BUCKET_W-1:0]      ring_ms [NB];
	int                                 open_slot       = 0;
	logic [fcfm_pkg::FLOW_W-1:0]        flow_rate       = '0;
	logic [fcfm_pkg::RESTART_W-1:0]     restart_tally   = '0;

	// stimulus stream state
	logic [CB-1:0] gen_count = '0;
	logic [31:0]   gen_stamp = '0;

	sample_t        sample_queue[$];
	meter_reading_t expected_readings[$];
	sample_t        on_bus;
	meter_reading_t want;

	int idle_pct        = 0;
	int gap_left        = 0;
	int stall_left      = 0;
	int hold_left       = 0;
	bit long_hold_done  = 1'b0;
	int error_count     = 0;
	int cycle_count     = 0;
	int items_accepted  = 0;
	int results_checked = 0;
	int n_ignored       = 0;
	int n_restarts      = 0;
	int n_flow_updates  = 0;
	int n_window_clears = 0;
	int n_cfg_writes    = 0;

	initial begin
		for (int i = 0; i < NB; i++) begin
			ring_ul[i] = '0;
			ring_ms[i] = '0;
		end
	end

	function automatic void clear_ring();
		for (int i = 0; i < NB; i++) begin
			ring_ul[i] = '0;
			ring_ms[i] = '0;
		end
		open_slot = 0;
		flow_rate = '0;
	endfunction

	// add to the open bucket; on close recompute the average and rotate
	function automatic bit bucket_add(logic [CB-1:0] ul, logic [31:0] ms);
		longint unsigned sum_ul;
		longint unsigned sum_ms;
		int k;
		k = open_slot;
		sum_ul = 0;
		sum_ms = 0;
		ring_ul[k] = ring_ul[k] + fcfm_pkg::BUCKET_W'(ul);
		ring_ms[k] = ring_ms[k] + ms[fcfm_pkg::BUCKET_W-1:0];
		if (ring_ms[k] < bucket_time_cfg)
			return 1'b0;
		for (int i = 0; i < NB; i++) begin
			sum_ul += ring_ul[i];
			sum_ms += ring_ms[i];
		end
		if (sum_ms == 0)
			flow_rate = '0;
		else
			flow_rate = fcfm_pkg::FLOW_W'((sum_ul * fcfm_pkg::MS_PER_S + sum_ms / 2) / sum_ms);
		k = (k + 1) % NB;
		open_slot = k;
		ring_ul[k] = '0;
		ring_ms[k] = '0;
		return 1'b1;
	endfunction

	// expected result of one accepted sample; updates the predicted state
	function automatic meter_reading_t meter_predict(sample_t s);
		meter_reading_t r;
		logic [31:0] dt;
		r = '0;
		if (!s.valid) begin
			n_ignored++;
		end else begin
			r.accepted = 1'b1;
			if (s.count == '0 || !s.turning) begin
				if (have_last) begin
					restart_tally = restart_tally + 1'b1;
					r.restart_seen = 1'b1;
					n_restarts++;
				end
				last_count = s.count;
				last_stamp = s.stamp;
				have_last = 1'b1;
				clear_ring();
			end else if (!have_last) begin
				last_count = s.count;
				last_stamp = s.stamp;
				have_last = 1'b1;
			end else begin
				dt = s.stamp - last_stamp;
				r.delta = s.count - last_count;
				last_count = s.count;
				last_stamp = s.stamp;
				if (dt != 0 && dt <= window_cfg) begin
					r.flow_updated = bucket_add(r.delta, dt);
					if (r.flow_updated)
						n_flow_updates++;
				end else if (dt > window_cfg) begin
					clear_ring();
					n_window_clears++;
				end
			end
		end
		r.restarts = restart_tally;
		r.flow = flow_rate;
		return r;
	endfunction

	task automatic check_field(input string name, input longint unsigned exp_v,
			input longint unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			error_count++;
		end
	endtask

	// input driver: offers queued samples, with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				expected_readings.push_back(meter_predict(on_bus));
				items_accepted++;
			end
			if (!push || !full) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if ($urandom_range(0, 99) < idle_pct) begin
					gap_left = $urandom_range(0, 15);
					push <= 1'b0;
				end else if (sample_queue.size() > 0) begin
					on_bus = sample_queue.pop_front();
					push <= 1'b1;
					counter_valid <= on_bus.valid;
					fuel_count <= on_bus.count;
					engine_turning <= on_bus.turning;
					time_ms <= on_bus.stamp;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// result monitor: pops with random stalls and one long hold
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_readings.size() == 0) begin
					$error("result item arrived with nothing expected");
					error_count++;
				end else begin
					want = expected_readings.pop_front();
					check_field("accepted", want.accepted, accepted);
					check_field("burned_ul", want.delta, burned_ul);
					check_field("restart_seen", want.restart_seen, restart_seen);
					check_field("restart_total", want.restarts, restart_total);
					check_field("flow_updated", want.flow_updated, flow_updated);
					check_field("flow_ul_per_s", want.flow, flow_ul_per_s);
				end
				results_checked++;
			end
			// long hold while the sender still has plenty queued
			if (!long_hold_done && results_checked >= 600 && sample_queue.size() > 30) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(0, 15);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic queue_sample(input logic v, input logic [CB-1:0] c, input logic t,
			input logic [31:0] s);
		sample_queue.push_back(sample_t'{valid: v, count: c, turning: t, stamp: s});
	endtask

	task automatic write_register(input logic [fcfm_pkg::CFG_IDX_W-1:0] idx,
			input logic [fcfm_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			fcfm_pkg::REG_BUCKET_TIME: bucket_time_cfg = data[fcfm_pkg::BUCKET_TIME_W-1:0];
			fcfm_pkg::REG_WINDOW_TIME: window_cfg = data;
			default: ;
		endcase
		n_cfg_writes++;
	endtask

	// wait until every queued sample went in and every result came out
	task automatic wait_drained();
		do
			@(negedge clk);
		while (sample_queue.size() > 0 || push || expected_readings.size() > 0);
	endtask

	// one random sample, mostly a well-formed continuation of the stream
	function automatic sample_t make_random_sample();
		sample_t s;
		int pick;
		int unsigned cap;
		pick = $urandom_range(0, 99);
		s.valid = 1'b1;
		s.turning = 1'b1;
		cap = bucket_time_cfg / 3;
		if (cap == 0)
			cap = 1;
		if (cap > window_cfg)
			cap = window_cfg;
		if (pick < 70) begin
			if ($urandom_range(0, 3) == 0)
				gen_stamp += $urandom_range(0, window_cfg);
			else
				gen_stamp += $urandom_range(1, cap);
			if ($urandom_range(0, 7) == 0)
				gen_count += CB'($urandom);
			else
				gen_count += CB'($urandom_range(0, 400));
		end else if (pick < 78) begin
			// ignored sample with arbitrary content
			s.valid = 1'b0;
			s.count = CB'($urandom);
			s.turning = 1'($urandom_range(0, 1));
			s.stamp = $urandom;
			return s;
		end else if (pick < 84) begin
			s.turning = 1'b0;
			gen_stamp += $urandom_range(0, cap);
			gen_count += CB'($urandom_range(0, 400));
		end else if (pick < 88) begin
			gen_stamp += $urandom_range(0, cap);
			gen_count = '0;
		end else if (pick < 94) begin
			// gap past the window
			if ($urandom_range(0, 1) == 0)
				gen_stamp += window_cfg + 1 + $urandom_range(0, 10);
			else
				gen_stamp += window_cfg + 1 + $urandom;
			gen_count += CB'($urandom_range(0, 400));
		end else if (pick < 97) begin
			gen_count += CB'($urandom_range(1, 400));
		end else begin
			s.turning = 1'($urandom_range(0, 1));
			gen_count = CB'($urandom);
			gen_stamp = $urandom;
		end
		s.count = gen_count;
		s.stamp = gen_stamp;
		return s;
	endfunction

	task automatic run_phase(input logic [fcfm_pkg::BUCKET_TIME_W-1:0] bt,
			input logic [fcfm_pkg::WINDOW_W-1:0] wt, input int n_valid, input int pct);
		sample_t s;
		int made;
		write_register(fcfm_pkg::REG_BUCKET_TIME, fcfm_pkg::CFG_DATA_W'(bt));
		write_register(fcfm_pkg::REG_WINDOW_TIME, wt);
		idle_pct = pct;
		made = 0;
		while (made < n_valid) begin
			s = make_random_sample();
			sample_queue.push_back(s);
			if (s.valid)
				made++;
		end
		wait_drained();
	endtask

	// timeout
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("run timed out after %0d cycles", cycle_count);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// main sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed cases at reset register values
		idle_pct = 10;
		queue_sample(1'b0, 15'h7FFF, 1'b1, 32'hFFFF_FFFF); // ignored before any sample
		queue_sample(1'b1, 15'h7FFF, 1'b1, 32'hFFFF_FF00); // first sample seeds
		queue_sample(1'b1, 15'd10, 1'b1, 32'h0000_0000);   // counter and clock wrap, closes
		queue_sample(1'b1, 15'd20, 1'b1, 32'h0000_0000);   // zero elapsed time
		queue_sample(1'b1, 15'd520, 1'b1, 32'd100);
		queue_sample(1'b1, 15'd1520, 1'b1, 32'd300);
		queue_sample(1'b1, 15'd2000, 1'b1, 32'd1300);      // gap equal to window
		queue_sample(1'b1, 15'd2100, 1'b1, 32'd2301);      // gap one past window
		queue_sample(1'b1, 15'd2099, 1'b1, 32'd2302);      // largest delta
		queue_sample(1'b1, 15'd2600, 1'b1, 32'd2552);
		queue_sample(1'b1, 15'd3100, 1'b1, 32'd2802);
		queue_sample(1'b1, 15'd3900, 1'b1, 32'd3052);
		queue_sample(1'b1, 15'd4000, 1'b1, 32'd3302);      // ring wraps around
		queue_sample(1'b1, 15'd4500, 1'b1, 32'd3552);
		queue_sample(1'b1, 15'd4700, 1'b0, 32'd3600);      // engine stopped
		queue_sample(1'b1, 15'd0, 1'b1, 32'd3650);         // zero counter
		queue_sample(1'b1, 15'd0, 1'b0, 32'd3700);         // both restart causes
		queue_sample(1'b0, 15'd0, 1'b0, 32'd0);            // ignored, all zero
		queue_sample(1'b1, 15'd5, 1'b1, 32'd3950);         // adds after a restart
		queue_sample(1'b1, 15'h7FFF, 1'b1, 32'd4200);
		gen_count = 15'h7FFF;
		gen_stamp = 32'd4200;
		wait_drained();

		// random streams over several register settings
		run_phase(14'd1, 16'd1, 150, 20);
		run_phase(14'd16383, 16'd65535, 200, 0);
		run_phase(14'd1, 16'd65535, 150, 30);
		run_phase(14'($urandom_range(1, 600)), 16'($urandom_range(100, 3000)), 250, 15);
		run_phase(14'($urandom_range(1, 16383)), 16'($urandom_range(1, 65535)), 200, 40);
		run_phase(fcfm_pkg::BUCKET_TIME_RST, fcfm_pkg::WINDOW_TIME_RST, 200, 0);

		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Run: %0d samples (%0d ignored), %0d results, %0d restarts, %0d flow updates",
			items_accepted, n_ignored, results_checked, n_restarts, n_flow_updates);
		$display("Run: %0d window clears, %0d register writes, output hold of %0d cycles",
			n_window_clears, n_cfg_writes, LONG_HOLD);
		if (error_count == 0 && expected_readings.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (expected_readings.size() != 0)
				$error("%0d expected results never arrived", expected_readings.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/fcfm_pkg.sv
rtl/fcfm_front.sv
rtl/fcfm_queue.sv
rtl/fcfm_back.sv
rtl/fuel_counter_flow_meter_unit.sv
tb/tb_fuel_counter_flow_meter_unit.sv
